>>> rtl/vdl_pkg.sv
`default_nettype none
package vdl_pkg;

  localparam int CHANNEL_BITS = 16;
  localparam logic [CHANNEL_BITS-1:0] CHAN_MAX = {CHANNEL_BITS{1'b1}};

  // magnitude of the transformed normal, normalized component, radicand
  localparam int MAG_W  = 49;
  localparam int NRM_W  = 30;
  localparam int RAD_W  = 62;
  localparam int NUM_W  = 48;
  localparam int ROOT_W = 32;
  localparam int DEN_W  = 31;
  localparam int QUO_W  = 20;

  localparam logic [47:0] RST_ROW0 = 48'd4096;
  localparam logic [47:0] RST_ROW1 = 48'd268435456;
  localparam logic [47:0] RST_ROW2 = 48'd17592186044416;
  localparam logic [47:0] RST_LDIR = 48'd140741783322624;
  localparam logic [47:0] RST_LCOL = 48'd56294995395379;
  localparam logic [47:0] RST_AMB  = 48'd14073748848844;
  localparam logic [63:0] RST_MAT  = 64'd4611756388245323776;

  typedef enum logic [2:0] {
    REG_ENABLE,
    REG_ROW0,
    REG_ROW1,
    REG_ROW2,
    REG_LDIR,
    REG_LCOL,
    REG_AMB,
    REG_MAT
  } vdl_reg_t;

  typedef struct packed {
    logic signed [15:0]      normal_x;
    logic signed [15:0]      normal_y;
    logic signed [15:0]      normal_z;
    logic [CHANNEL_BITS-1:0] color_red;
    logic [CHANNEL_BITS-1:0] color_green;
    logic [CHANNEL_BITS-1:0] color_blue;
    logic [CHANNEL_BITS-1:0] color_alpha;
  } vdl_in_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] out_red;
    logic [CHANNEL_BITS-1:0] out_green;
    logic [CHANNEL_BITS-1:0] out_blue;
    logic [CHANNEL_BITS-1:0] out_alpha;
    logic                    normal_valid;
  } vdl_out_t;

  typedef struct packed {
    logic        enable;
    logic [47:0] row0;
    logic [47:0] row1;
    logic [47:0] row2;
    logic [47:0] ldir;
    logic [47:0] lcol;
    logic [47:0] amb;
    logic [63:0] mat;
  } vdl_cfg_t;

  typedef struct packed {
    logic    vld;
    logic    lit;
    vdl_in_t word;
  } vdl_side_t;

  // advance side data one stage; drop the valid bit while clr is high
  function automatic vdl_side_t side_adv(input vdl_side_t s, input logic clr);
    vdl_side_t r;
    r     = s;
    r.vld = s.vld && !clr;
    return r;
  endfunction

  typedef struct packed {
    vdl_side_t        side;
    logic             nvalid;
    logic             dpos;
    logic [NUM_W-1:0] num;
    logic [RAD_W-1:0] rad;
  } vdl_fs_t;

  typedef struct packed {
    vdl_side_t         side;
    logic              nvalid;
    logic              dpos;
    logic [NUM_W-1:0]  num;
    logic [ROOT_W-1:0] len;
  } vdl_sd_t;

  typedef struct packed {
    vdl_side_t        side;
    logic             nvalid;
    logic             dpos;
    logic [QUO_W-1:0] quo;
  } vdl_ds_t;

endpackage
`default_nettype wire

>>> rtl/vdl_front.sv
`default_nettype none
module vdl_front (
  input  logic               clk,
  input  logic               rst,
  input  vdl_pkg::vdl_side_t side_i,
  input  vdl_pkg::vdl_cfg_t  cfg,
  output vdl_pkg::vdl_fs_t   fs_o
);

  logic [47:0]        rows [3];
  logic signed [15:0] a [3][3];
  logic signed [15:0] ldir [3];

  assign rows[0] = cfg.row0;
  assign rows[1] = cfg.row1;
  assign rows[2] = cfg.row2;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        a[i][j] = $signed(rows[i][16*j +: 16]);
      end
      ldir[i] = $signed(cfg.ldir[16*i +: 16]);
    end
  end

  // stage 1: cofactors
  vdl_pkg::vdl_side_t s1;
  logic signed [32:0] cof [3][3];
  logic signed [31:0] cp1 [3][3];
  logic signed [31:0] cp2 [3][3];
  logic signed [32:0] cof_next [3][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        cp1[i][j] = a[(i+1)%3][(j+1)%3] * a[(i+2)%3][(j+2)%3];
        cp2[i][j] = a[(i+1)%3][(j+2)%3] * a[(i+2)%3][(j+1)%3];
        cof_next[i][j] = 33'(cp1[i][j]) - 33'(cp2[i][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    s1  <= vdl_pkg::side_adv(side_i, rst);
    cof <= cof_next;
  end

  // stage 2: determinant and transform products
  vdl_pkg::vdl_side_t s2;
  logic signed [15:0] nrm [3];
  logic signed [48:0] detp [3];
  logic signed [48:0] np [3][3];
  logic signed [48:0] detp_next [3];
  logic signed [48:0] np_next [3][3];

  assign nrm[0] = s1.word.normal_x;
  assign nrm[1] = s1.word.normal_y;
  assign nrm[2] = s1.word.normal_z;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      detp_next[j] = a[0][j] * cof[0][j];
      for (int i = 0; i < 3; i++) begin
        np_next[i][j] = cof[i][j] * nrm[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    s2   <= vdl_pkg::side_adv(s1, rst);
    detp <= detp_next;
    np   <= np_next;
  end

  // stage 3: sums
  vdl_pkg::vdl_side_t s3;
  logic signed [50:0] det_sum;
  logic signed [50:0] n3 [3];
  logic signed [50:0] n3_next [3];
  logic               det_neg3, det_zero3;

  always_comb begin
    det_sum = 51'(detp[0]) + 51'(detp[1]) + 51'(detp[2]);
    for (int i = 0; i < 3; i++) begin
      n3_next[i] = 51'(np[i][0]) + 51'(np[i][1]) + 51'(np[i][2]);
    end
  end

  always_ff @(posedge clk) begin
    s3        <= vdl_pkg::side_adv(s2, rst);
    n3        <= n3_next;
    det_neg3  <= det_sum[50];
    det_zero3 <= (det_sum == '0);
  end

  // stage 4: orient by determinant sign, split into sign and magnitude
  vdl_pkg::vdl_side_t s4;
  logic [vdl_pkg::MAG_W-1:0] m4 [3];
  logic [vdl_pkg::MAG_W-1:0] m4_next [3];
  logic [2:0]                neg4, neg4_next;
  logic                      dz4;
  logic signed [50:0]        ov [3];
  logic signed [50:0]        mag [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ov[i]        = det_neg3 ? -n3[i] : n3[i];
      neg4_next[i] = ov[i][50];
      mag[i]       = ov[i][50] ? -ov[i] : ov[i];
      m4_next[i]   = mag[i][vdl_pkg::MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    s4   <= vdl_pkg::side_adv(s3, rst);
    m4   <= m4_next;
    neg4 <= neg4_next;
    dz4  <= det_zero3;
  end

  // stage 5: leading one of the largest magnitude
  vdl_pkg::vdl_side_t s5;
  logic [vdl_pkg::MAG_W-1:0] m5 [3];
  logic [vdl_pkg::MAG_W-1:0] orv;
  logic [5:0]                pos5, pos_next;
  logic [2:0]                neg5;
  logic                      nv5;

  always_comb begin
    orv      = m4[0] | m4[1] | m4[2];
    pos_next = '0;
    for (int b = 0; b < vdl_pkg::MAG_W; b++) begin
      if (orv[b]) pos_next = 6'(b);
    end
  end

  always_ff @(posedge clk) begin
    s5   <= vdl_pkg::side_adv(s4, rst);
    m5   <= m4;
    neg5 <= neg4;
    pos5 <= pos_next;
    nv5  <= !dz4 && (orv != '0);
  end

  // stage 6: shift so the largest magnitude lands in 2^29..2^30-1
  localparam logic [5:0] TOP = 6'(vdl_pkg::NRM_W - 1);
  vdl_pkg::vdl_side_t s6;
  logic [vdl_pkg::NRM_W-1:0] mn6 [3];
  logic [vdl_pkg::NRM_W-1:0] mn6_next [3];
  logic [vdl_pkg::MAG_W-1:0] sh [3];
  logic [2:0]                neg6;
  logic                      nv6;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sh[i] = (pos5 >= TOP) ? (m5[i] >> (pos5 - TOP)) : (m5[i] << (TOP - pos5));
      mn6_next[i] = sh[i][vdl_pkg::NRM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    s6   <= vdl_pkg::side_adv(s5, rst);
    mn6  <= mn6_next;
    neg6 <= neg5;
    nv6  <= nv5;
  end

  // stage 7: squares and light products
  vdl_pkg::vdl_side_t s7;
  logic [59:0]        sq7 [3];
  logic [59:0]        sq7_next [3];
  logic signed [46:0] dp7 [3];
  logic signed [46:0] dp7_next [3];
  logic signed [30:0] sv [3];
  logic               nv7;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq7_next[i] = 60'(mn6[i]) * 60'(mn6[i]);
      sv[i]       = neg6[i] ? -$signed({1'b0, mn6[i]}) : $signed({1'b0, mn6[i]});
      dp7_next[i] = sv[i] * ldir[i];
    end
  end

  always_ff @(posedge clk) begin
    s7  <= vdl_pkg::side_adv(s6, rst);
    sq7 <= sq7_next;
    dp7 <= dp7_next;
    nv7 <= nv6;
  end

  // stage 8: radicand and doubled, negated dot product
  vdl_pkg::vdl_fs_t   fs_next;
  logic signed [48:0] dsum, dneg;

  always_comb begin
    dsum            = 49'(dp7[0]) + 49'(dp7[1]) + 49'(dp7[2]);
    dneg            = -dsum;
    fs_next.side    = vdl_pkg::side_adv(s7, rst);
    fs_next.nvalid  = nv7;
    fs_next.dpos    = !dneg[48] && (dneg != '0);
    fs_next.num     = {dneg[vdl_pkg::NUM_W-2:0], 1'b0};
    fs_next.rad     = vdl_pkg::RAD_W'(sq7[0]) + vdl_pkg::RAD_W'(sq7[1])
                    + vdl_pkg::RAD_W'(sq7[2]);
  end

  always_ff @(posedge clk) begin
    fs_o <= fs_next;
  end

endmodule
`default_nettype wire

>>> rtl/vdl_sqrt.sv
`default_nettype none
module vdl_sqrt (
  input  logic             clk,
  input  logic             rst,
  input  vdl_pkg::vdl_fs_t fs_i,
  output vdl_pkg::vdl_sd_t sd_o
);

  localparam int STAGES = 8;
  localparam int STEPS  = vdl_pkg::ROOT_W / STAGES;

  typedef struct packed {
    vdl_pkg::vdl_side_t        side;
    logic                      nvalid;
    logic                      dpos;
    logic [vdl_pkg::NUM_W-1:0] num;
    logic [2*vdl_pkg::ROOT_W-1:0] rad;
    logic [vdl_pkg::ROOT_W+1:0]   rem;
    logic [vdl_pkg::ROOT_W-1:0]   root;
  } sq_t;

  sq_t st [STAGES];
  sq_t cur [STAGES];
  sq_t nxt [STAGES];
  logic [vdl_pkg::ROOT_W+2:0] tmp [STAGES][STEPS];
  logic [vdl_pkg::ROOT_W+2:0] trial [STAGES][STEPS];

  always_comb begin
    cur[0].side   = fs_i.side;
    cur[0].nvalid = fs_i.nvalid;
    cur[0].dpos   = fs_i.dpos;
    cur[0].num    = fs_i.num;
    cur[0].rad    = (2*vdl_pkg::ROOT_W)'(fs_i.rad);
    cur[0].rem    = '0;
    cur[0].root   = '0;
    for (int s = 1; s < STAGES; s++) cur[s] = st[s-1];
    for (int s = 0; s < STAGES; s++) begin
      nxt[s]      = cur[s];
      nxt[s].side = vdl_pkg::side_adv(cur[s].side, rst);
      // two radicand bits per step, one root bit out
      for (int k = 0; k < STEPS; k++) begin
        tmp[s][k]   = {nxt[s].rem[vdl_pkg::ROOT_W:0],
                       nxt[s].rad[2*vdl_pkg::ROOT_W-1 -: 2]};
        trial[s][k] = {1'b0, nxt[s].root, 2'b01};
        nxt[s].rad  = nxt[s].rad << 2;
        if (tmp[s][k] >= trial[s][k]) begin
          nxt[s].rem  = (vdl_pkg::ROOT_W+2)'(tmp[s][k] - trial[s][k]);
          nxt[s].root = {nxt[s].root[vdl_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          nxt[s].rem  = (vdl_pkg::ROOT_W+2)'(tmp[s][k]);
          nxt[s].root = {nxt[s].root[vdl_pkg::ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < STAGES; s++) st[s] <= nxt[s];
  end

  assign sd_o.side   = st[STAGES-1].side;
  assign sd_o.nvalid = st[STAGES-1].nvalid;
  assign sd_o.dpos   = st[STAGES-1].dpos;
  assign sd_o.num    = st[STAGES-1].num;
  assign sd_o.len    = st[STAGES-1].root;

endmodule
`default_nettype wire

>>> rtl/vdl_div.sv
`default_nettype none
module vdl_div (
  input  logic             clk,
  input  logic             rst,
  input  vdl_pkg::vdl_sd_t sd_i,
  output vdl_pkg::vdl_ds_t ds_o
);

  localparam int STAGES = 5;
  localparam int STEPS  = vdl_pkg::QUO_W / STAGES;
  localparam int TW     = vdl_pkg::DEN_W + vdl_pkg::QUO_W;

  typedef struct packed {
    vdl_pkg::vdl_side_t        side;
    logic                      nvalid;
    logic                      dpos;
    logic [vdl_pkg::DEN_W-1:0] den;
    logic [vdl_pkg::NUM_W-1:0] rem;
    logic [vdl_pkg::QUO_W-1:0] quo;
  } dv_t;

  dv_t st [STAGES];
  dv_t cur [STAGES];
  dv_t nxt [STAGES];
  logic [TW-1:0] t [STAGES][STEPS];

  always_comb begin
    cur[0].side   = sd_i.side;
    cur[0].nvalid = sd_i.nvalid;
    cur[0].dpos   = sd_i.dpos;
    cur[0].den    = sd_i.len[vdl_pkg::DEN_W-1:0];
    cur[0].rem    = sd_i.num;
    cur[0].quo    = '0;
    for (int s = 1; s < STAGES; s++) cur[s] = st[s-1];
    for (int s = 0; s < STAGES; s++) begin
      nxt[s]      = cur[s];
      nxt[s].side = vdl_pkg::side_adv(cur[s].side, rst);
      // restoring division, quotient bits from the top
      for (int k = 0; k < STEPS; k++) begin
        t[s][k] = TW'(nxt[s].den) << (vdl_pkg::QUO_W - 1 - s*STEPS - k);
        if (TW'(nxt[s].rem) >= t[s][k]) begin
          nxt[s].rem = nxt[s].rem - t[s][k][vdl_pkg::NUM_W-1:0];
          nxt[s].quo[vdl_pkg::QUO_W - 1 - s*STEPS - k] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < STAGES; s++) st[s] <= nxt[s];
  end

  assign ds_o.side   = st[STAGES-1].side;
  assign ds_o.nvalid = st[STAGES-1].nvalid;
  assign ds_o.dpos   = st[STAGES-1].dpos;
  assign ds_o.quo    = st[STAGES-1].quo;

endmodule
`default_nettype wire

>>> rtl/vdl_shade.sv
`default_nettype none
module vdl_shade (
  input  logic              clk,
  input  logic              rst,
  input  vdl_pkg::vdl_ds_t  ds_i,
  input  vdl_pkg::vdl_cfg_t cfg,
  output logic              done,
  output vdl_pkg::vdl_out_t result
);

  localparam int CB = vdl_pkg::CHANNEL_BITS;
  localparam int TW = 24 + CB + 1;
  localparam logic [16:0] DIFF_ONE = 17'd65536;

  function automatic logic [CB-1:0] to_chan(input logic [29:0] q);
    logic [TW-1:0] t;
    t = (TW'(q[23:0]) << CB) - TW'(q[23:0]) + (TW'(1) << 23);
    if (q[29:24] != '0) return vdl_pkg::CHAN_MAX;
    return t[24 +: CB];
  endfunction

  // stage 1: clamp diffuse
  vdl_pkg::vdl_side_t s1;
  logic        nv1;
  logic [16:0] diff1, diff_next;

  always_comb begin
    if (!ds_i.nvalid || !ds_i.dpos) diff_next = '0;
    else if (ds_i.quo > 20'(DIFF_ONE)) diff_next = DIFF_ONE;
    else diff_next = ds_i.quo[16:0];
  end

  always_ff @(posedge clk) begin
    s1    <= vdl_pkg::side_adv(ds_i.side, rst);
    nv1   <= ds_i.nvalid;
    diff1 <= diff_next;
  end

  // stage 2: light times diffuse
  vdl_pkg::vdl_side_t s2;
  logic        nv2;
  logic [32:0] lp2 [3];

  always_ff @(posedge clk) begin
    s2  <= vdl_pkg::side_adv(s1, rst);
    nv2 <= nv1;
    for (int k = 0; k < 3; k++) lp2[k] <= 33'(cfg.lcol[16*k +: 16]) * 33'(diff1);
  end

  // stage 3: add ambient
  vdl_pkg::vdl_side_t s3;
  logic        nv3;
  logic [33:0] sum3 [3];

  always_ff @(posedge clk) begin
    s3  <= vdl_pkg::side_adv(s2, rst);
    nv3 <= nv2;
    for (int k = 0; k < 3; k++) begin
      sum3[k] <= {2'b00, cfg.amb[16*k +: 16], 16'h0000} + 34'(lp2[k]);
    end
  end

  // stage 4: material
  vdl_pkg::vdl_side_t s4;
  logic        nv4;
  logic [49:0] p4 [3];

  always_ff @(posedge clk) begin
    s4  <= vdl_pkg::side_adv(s3, rst);
    nv4 <= nv3;
    for (int k = 0; k < 3; k++) p4[k] <= 50'(cfg.mat[16*k +: 16]) * 50'(sum3[k]);
  end

  // stage 5: scale to channel width, select pass-through when unlit
  vdl_pkg::vdl_out_t res_next;

  always_comb begin
    if (s4.lit) begin
      res_next.out_red      = to_chan(p4[0][49:20]);
      res_next.out_green    = to_chan(p4[1][49:20]);
      res_next.out_blue     = to_chan(p4[2][49:20]);
      res_next.out_alpha    = to_chan({4'b0000, cfg.mat[63:48], 10'b0});
      res_next.normal_valid = nv4;
    end else begin
      res_next.out_red      = s4.word.color_red;
      res_next.out_green    = s4.word.color_green;
      res_next.out_blue     = s4.word.color_blue;
      res_next.out_alpha    = s4.word.color_alpha;
      res_next.normal_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s4.vld;
    end
    result <= res_next;
  end

endmodule
`default_nettype wire

>>> rtl/vertex_diffuse_lighting.sv
`default_nettype none
// Per-vertex directional diffuse lighting.
// Input: raise start with a normal and current color on in_word; a word is
// taken at every clock edge where start is high and busy is low. busy never
// rises, so a vertex may enter every cycle.
// Output: done pulses for one cycle with the lit color (or the passed-through
// color when lighting is off) and normal_valid on result. There is no back
// pressure: the receiver must take each word in the cycle it appears.
// Path: a taken word passes 26 register stages (8 transform/normalize,
// 8 square-root stages of 4 root bits, 5 divider stages of 4 quotient
// bits, 5 color stages) on its way to done and result. Throughput: one
// vertex per cycle.
// Configuration: write_enable with write_index and write_data writes one
// register at the clock edge, with no wait. Write only while no vertex is
// in flight.
// Reset (rst, synchronous): registers return to identity matrix, light
// along -z and their listed defaults; words in flight are dropped.
module vertex_diffuse_lighting (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  vdl_pkg::vdl_in_t  in_word,
  output logic              done,
  output vdl_pkg::vdl_out_t result,
  input  logic              write_enable,
  input  logic [2:0]        write_index,
  input  logic [63:0]       write_data
);

  vdl_pkg::vdl_cfg_t  cfg;
  vdl_pkg::vdl_side_t side_in;
  vdl_pkg::vdl_fs_t   fs;
  vdl_pkg::vdl_sd_t   sd;
  vdl_pkg::vdl_ds_t   ds;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable <= 1'b0;
      cfg.row0   <= vdl_pkg::RST_ROW0;
      cfg.row1   <= vdl_pkg::RST_ROW1;
      cfg.row2   <= vdl_pkg::RST_ROW2;
      cfg.ldir   <= vdl_pkg::RST_LDIR;
      cfg.lcol   <= vdl_pkg::RST_LCOL;
      cfg.amb    <= vdl_pkg::RST_AMB;
      cfg.mat    <= vdl_pkg::RST_MAT;
    end else if (write_enable) begin
      unique case (vdl_pkg::vdl_reg_t'(write_index))
        vdl_pkg::REG_ENABLE: cfg.enable <= write_data[0];
        vdl_pkg::REG_ROW0:   cfg.row0   <= write_data[47:0];
        vdl_pkg::REG_ROW1:   cfg.row1   <= write_data[47:0];
        vdl_pkg::REG_ROW2:   cfg.row2   <= write_data[47:0];
        vdl_pkg::REG_LDIR:   cfg.ldir   <= write_data[47:0];
        vdl_pkg::REG_LCOL:   cfg.lcol   <= write_data[47:0];
        vdl_pkg::REG_AMB:    cfg.amb    <= write_data[47:0];
        vdl_pkg::REG_MAT:    cfg.mat    <= write_data;
        default: ;
      endcase
    end
  end

  assign side_in.vld  = start && !busy;
  assign side_in.lit  = cfg.enable;
  assign side_in.word = in_word;

  vdl_front u_front (
    .clk    (clk),
    .rst    (rst),
    .side_i (side_in),
    .cfg    (cfg),
    .fs_o   (fs)
  );

  vdl_sqrt u_sqrt (
    .clk  (clk),
    .rst  (rst),
    .fs_i (fs),
    .sd_o (sd)
  );

  vdl_div u_div (
    .clk  (clk),
    .rst  (rst),
    .sd_i (sd),
    .ds_o (ds)
  );

  vdl_shade u_shade (
    .clk    (clk),
    .rst    (rst),
    .ds_i   (ds),
    .cfg    (cfg),
    .done   (done),
    .result (result)
  );

endmodule
`default_nettype wire
